@@ hw/rtl/crc_checked_ring_record_log_core_macros.svh @@
// assertion helpers shared by the checker
`ifndef CRC_CHECKED_RING_RECORD_LOG_CORE_MACROS_SVH
`define CRC_CHECKED_RING_RECORD_LOG_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CRCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define CRCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/crcl_pkg.sv @@
package crcl_pkg;

    localparam int ADDRESS_BITS_DEF = 13;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int SLOT_W           = 10;
    localparam int LEN_W            = 13;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  MARK_COMMIT = 8'hFE;
    localparam logic [7:0]  MARK_FREE   = 8'hFF;

    typedef enum logic [2:0] {
        OP_SCAN_BEGIN = 3'd0,
        OP_SCAN_BYTE  = 3'd1,
        OP_FORMAT     = 3'd2,
        OP_PUT        = 3'd3,
        OP_STATUS     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_VERDICT = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_ADDRESS   = 2'd0,
        REG_PAYLOAD_LENGTH = 2'd1,
        REG_SLOT_COUNT     = 2'd2
    } t_reg;

    typedef struct packed {
        logic [LEN_W-1:0]  base;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_item;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

@@ hw/rtl/crcl_front.sv @@
module crcl_front import crcl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  [2:0] i_op,
    input  logic  [7:0] i_data_byte,
    input  logic  i_q_full,
    output logic  o_push,
    output t_item o_push_item
);

    logic  r_valid, n_valid;
    t_item r_item;
    logic  in_acc;
    logic  op_known;

    assign o_in_stall  = r_valid && i_q_full;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign op_known    = (i_op <= OP_STATUS);
    assign o_push      = r_valid && !i_q_full;
    assign o_push_item = r_item;

    // unknown ops are dropped here, they have no effect
    always_comb begin
        n_valid = (r_valid && i_q_full) || (in_acc && op_known);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && op_known) begin
            r_item.op   <= t_op'(i_op);
            r_item.data <= i_data_byte;
        end
    end

endmodule

@@ hw/rtl/crcl_queue.sv @@
module crcl_queue import crcl_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

@@ hw/rtl/crcl_rem.sv @@
module crcl_rem import crcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SLOT_W:0]   i_dividend,
    input  logic [SLOT_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_rem
);

    localparam int DVD_W = SLOT_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_rem, r_dvd;
    logic [DVD_W-1:0] trial;
    logic             ge;

    // restoring remainder, one dividend bit per cycle
    assign trial  = {r_rem[DVD_W-2:0], r_dvd[DVD_W-1]};
    assign ge     = (trial >= {1'b0, i_divisor});
    assign o_done = r_done;
    assign o_rem  = r_rem[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_rem  <= '0;
                r_dvd  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? (trial - {1'b0, i_divisor}) : trial;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/crcl_back.sv @@
module crcl_back import crcl_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_valid,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_kind,
    output logic [ADDRESS_BITS-1:0] o_write_address,
    output logic [7:0]              o_write_data,
    output logic                    o_slot_valid,
    output logic                    o_latest_valid,
    output logic [ADDRESS_BITS-1:0] o_latest_payload_address,
    output logic [31:0]             o_latest_sequence,
    output logic                    o_last
);

    typedef logic [ADDRESS_BITS-1:0] t_addr;

    typedef enum logic [6:0] {
        S_RUN  = 7'b0000001,
        S_MOD  = 7'b0000010,
        S_ADDR = 7'b0000100,
        S_SEQ  = 7'b0001000,
        S_PAY  = 7'b0010000,
        S_CRC  = 7'b0100000,
        S_MARK = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic              r_newest_valid, n_newest_valid;
    logic [SLOT_W-1:0] r_newest_index, n_newest_index;
    logic [31:0]       r_newest_seq, n_newest_seq;
    logic [SLOT_W-1:0] r_scan_slot, n_scan_slot;
    logic [13:0]       r_byte_pos, n_byte_pos;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_stored_crc, n_stored_crc;
    logic [31:0]       r_scan_seq, n_scan_seq;
    logic [7:0]        r_scan_mark, n_scan_mark;
    logic [SLOT_W-1:0] r_target_slot, n_target_slot;
    t_addr             r_target_addr, n_target_addr;
    logic [31:0]       r_put_seq, n_put_seq;
    logic [SLOT_W-1:0] r_format_cnt, n_format_cnt;
    logic [13:0]       r_put_pos, n_put_pos;
    logic [31:0]       r_put_crc, n_put_crc;
    logic [7:0]        r_put_byte, n_put_byte;
    logic [1:0]        r_step, n_step;

    logic              r_out_valid;
    t_kind             r_kind;
    t_addr             r_waddr, r_laddr;
    logic [7:0]        r_wdata;
    logic              r_sv, r_lvalid, r_last;
    logic [31:0]       r_lseq;

    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] cnt;
    logic [13:0]       len14, slot_size, end_pos, pos_diff, pay_pos_n;
    logic              out_ready;
    logic [7:0]        b, pay_byte, seq_byte, crc_out_byte;
    logic [31:0]       crc_final;
    logic              pay_end;
    logic [1:0]        seq_lane;
    logic [31:0]       stored_upd, seq_diff;
    logic              scan_ok, take;
    logic [SLOT_W-1:0] fc_eff;
    logic              fmt_done;

    logic              emit, e_sv, e_last, use_fmt_addr, load_target, rem_start;
    t_kind             e_kind;
    t_addr             e_addr_raw;
    logic [7:0]        e_data;

    logic [SLOT_W-1:0] mul_idx;
    logic [23:0]       mul_full;
    t_addr             slot_addr;
    logic [SLOT_W:0]   rem_dividend;
    logic              rem_done;
    logic [SLOT_W-1:0] rem_value;

    crcl_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (cnt),
        .o_done     (rem_done),
        .o_rem      (rem_value)
    );

    assign len          = (i_cfg.len == '0) ? LEN_W'(1) : i_cfg.len;
    assign cnt          = (i_cfg.count == '0) ? SLOT_W'(1) : i_cfg.count;
    assign len14        = {1'b0, len};
    assign slot_size    = len14 + 14'd9;
    assign end_pos      = len14 + 14'd8;
    assign pos_diff     = r_byte_pos - (len14 + 14'd5);
    assign out_ready    = !r_out_valid || !i_out_stall;
    assign b            = i_q_item.data;
    assign rem_dividend = {1'b0, r_newest_index} + 1'b1;

    assign pay_byte     = (r_state == S_PAY) ? r_put_byte : b;
    assign pay_pos_n    = r_put_pos + 1'b1;
    assign pay_end      = (pay_pos_n >= len14) || (pay_pos_n == '0);
    assign seq_byte     = r_put_seq[{r_step, 3'b000} +: 8];
    assign crc_final    = r_put_crc ^ CRC_INIT;
    assign crc_out_byte = crc_final[{r_step, 3'b000} +: 8];

    assign seq_lane     = r_byte_pos[1:0] - 2'd1;
    assign stored_upd   = r_stored_crc | ({24'd0, b} << {pos_diff[1:0], 3'b000});
    assign seq_diff     = r_scan_seq - r_newest_seq;

    assign fc_eff       = (r_format_cnt >= cnt) ? '0 : r_format_cnt;
    assign fmt_done     = ({1'b0, fc_eff} + 1'b1) >= {1'b0, cnt};

    always_comb begin
        n_state        = r_state;
        n_newest_valid = r_newest_valid;
        n_newest_index = r_newest_index;
        n_newest_seq   = r_newest_seq;
        n_scan_slot    = r_scan_slot;
        n_byte_pos     = r_byte_pos;
        n_crc          = r_crc;
        n_stored_crc   = r_stored_crc;
        n_scan_seq     = r_scan_seq;
        n_scan_mark    = r_scan_mark;
        n_target_slot  = r_target_slot;
        n_put_seq      = r_put_seq;
        n_format_cnt   = r_format_cnt;
        n_put_pos      = r_put_pos;
        n_put_crc      = r_put_crc;
        n_put_byte     = r_put_byte;
        n_step         = r_step;
        o_q_pop        = 1'b0;
        emit           = 1'b0;
        e_kind         = KIND_WRITE;
        e_addr_raw     = '0;
        e_data         = '0;
        e_sv           = 1'b0;
        e_last         = 1'b0;
        use_fmt_addr   = 1'b0;
        load_target    = 1'b0;
        rem_start      = 1'b0;
        scan_ok        = 1'b0;
        take           = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (i_q_valid && out_ready) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.op)
                        OP_SCAN_BEGIN: begin
                            n_newest_valid = 1'b0;
                            n_newest_index = '0;
                            n_newest_seq   = '0;
                            n_scan_slot    = '0;
                            n_byte_pos     = '0;
                            n_crc          = CRC_INIT;
                            n_stored_crc   = '0;
                            n_scan_seq     = '0;
                            n_scan_mark    = '0;
                        end
                        OP_SCAN_BYTE: begin
                            if (r_scan_slot < cnt) begin
                                if (r_byte_pos == '0) begin
                                    n_scan_mark = b;
                                end else if (r_byte_pos <= 14'd4) begin
                                    n_scan_seq = r_scan_seq | ({24'd0, b} << {seq_lane, 3'b000});
                                    n_crc      = crc_byte(r_crc, b);
                                end else if (r_byte_pos < len14 + 14'd5) begin
                                    n_crc = crc_byte(r_crc, b);
                                end else if (pos_diff < 14'd4) begin
                                    n_stored_crc = stored_upd;
                                end
                                if (r_byte_pos >= end_pos) begin
                                    // crc and sequence are complete before the last slot byte
                                    scan_ok = (r_scan_mark == MARK_COMMIT) &&
                                              ((r_crc ^ CRC_INIT) == n_stored_crc);
                                    take = scan_ok && (!r_newest_valid ||
                                           (seq_diff != '0 && !seq_diff[31]));
                                    if (take) begin
                                        n_newest_valid = 1'b1;
                                        n_newest_index = r_scan_slot;
                                        n_newest_seq   = r_scan_seq;
                                    end
                                    n_scan_slot  = r_scan_slot + 1'b1;
                                    n_byte_pos   = '0;
                                    n_crc        = CRC_INIT;
                                    n_stored_crc = '0;
                                    n_scan_seq   = '0;
                                    n_scan_mark  = '0;
                                    emit         = 1'b1;
                                    e_kind       = KIND_VERDICT;
                                    e_sv         = scan_ok;
                                    e_last       = (n_scan_slot >= cnt);
                                end else begin
                                    n_byte_pos = r_byte_pos + 1'b1;
                                end
                            end
                        end
                        OP_FORMAT: begin
                            emit         = 1'b1;
                            use_fmt_addr = 1'b1;
                            e_data       = MARK_FREE;
                            e_last       = fmt_done;
                            if (fmt_done) begin
                                n_newest_valid = 1'b0;
                                n_newest_index = '0;
                                n_newest_seq   = '0;
                                n_format_cnt   = '0;
                            end else begin
                                n_format_cnt = fc_eff + 1'b1;
                            end
                        end
                        OP_PUT: begin
                            n_put_byte = b;
                            if (r_put_pos == '0) begin
                                n_put_seq = r_newest_seq + 1'b1;
                                n_put_crc = CRC_INIT;
                                n_step    = '0;
                                if (r_newest_valid) begin
                                    rem_start = 1'b1;
                                    n_state   = S_MOD;
                                end else begin
                                    n_target_slot = '0;
                                    n_state       = S_ADDR;
                                end
                            end else begin
                                emit       = 1'b1;
                                e_addr_raw = r_target_addr + t_addr'(5) + t_addr'(r_put_pos);
                                e_data     = pay_byte;
                                n_put_crc  = crc_byte(r_put_crc, pay_byte);
                                n_put_pos  = pay_end ? '0 : pay_pos_n;
                                if (pay_end) begin
                                    n_step  = '0;
                                    n_state = S_CRC;
                                end
                            end
                        end
                        OP_STATUS: begin
                            emit   = 1'b1;
                            e_kind = KIND_STATUS;
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (rem_done) begin
                    n_target_slot = rem_value;
                    n_state       = S_ADDR;
                end
            end
            S_ADDR: begin
                load_target = 1'b1;
                n_state     = S_SEQ;
            end
            S_SEQ: begin
                if (out_ready) begin
                    emit       = 1'b1;
                    e_addr_raw = r_target_addr + t_addr'(1) + t_addr'(r_step);
                    e_data     = seq_byte;
                    n_put_crc  = crc_byte(r_put_crc, seq_byte);
                    n_step     = r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        n_state = S_PAY;
                    end
                end
            end
            S_PAY: begin
                if (out_ready) begin
                    emit       = 1'b1;
                    e_addr_raw = r_target_addr + t_addr'(5) + t_addr'(r_put_pos);
                    e_data     = pay_byte;
                    n_put_crc  = crc_byte(r_put_crc, pay_byte);
                    n_put_pos  = pay_end ? '0 : pay_pos_n;
                    n_step     = '0;
                    n_state    = pay_end ? S_CRC : S_RUN;
                end
            end
            S_CRC: begin
                if (out_ready) begin
                    emit       = 1'b1;
                    e_addr_raw = r_target_addr + t_addr'(5) + t_addr'(len) + t_addr'(r_step);
                    e_data     = crc_out_byte;
                    n_step     = r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                if (out_ready) begin
                    emit           = 1'b1;
                    e_addr_raw     = r_target_addr;
                    e_data         = MARK_COMMIT;
                    e_last         = 1'b1;
                    n_newest_valid = 1'b1;
                    n_newest_index = r_target_slot;
                    n_newest_seq   = r_put_seq;
                    n_put_crc      = CRC_INIT;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // one shared slot address multiplier
    assign mul_idx       = use_fmt_addr ? fc_eff : (load_target ? r_target_slot : n_newest_index);
    assign mul_full      = {14'd0, mul_idx} * {10'd0, slot_size};
    assign slot_addr     = t_addr'(i_cfg.base) + mul_full[ADDRESS_BITS-1:0];
    assign n_target_addr = load_target ? slot_addr : r_target_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_RUN;
            r_newest_valid <= 1'b0;
            r_newest_index <= '0;
            r_newest_seq   <= '0;
            r_scan_slot    <= '0;
            r_byte_pos     <= '0;
            r_crc          <= CRC_INIT;
            r_stored_crc   <= '0;
            r_scan_seq     <= '0;
            r_scan_mark    <= '0;
            r_target_slot  <= '0;
            r_target_addr  <= '0;
            r_put_seq      <= '0;
            r_format_cnt   <= '0;
            r_put_pos      <= '0;
            r_put_crc      <= CRC_INIT;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_newest_valid <= n_newest_valid;
            r_newest_index <= n_newest_index;
            r_newest_seq   <= n_newest_seq;
            r_scan_slot    <= n_scan_slot;
            r_byte_pos     <= n_byte_pos;
            r_crc          <= n_crc;
            r_stored_crc   <= n_stored_crc;
            r_scan_seq     <= n_scan_seq;
            r_scan_mark    <= n_scan_mark;
            r_target_slot  <= n_target_slot;
            r_target_addr  <= n_target_addr;
            r_put_seq      <= n_put_seq;
            r_format_cnt   <= n_format_cnt;
            r_put_pos      <= n_put_pos;
            r_put_crc      <= n_put_crc;
            r_step         <= n_step;
            if (out_ready) begin
                r_out_valid <= emit;
            end
        end
    end

    // result register, info fields show the newest record after this item
    always_ff @(posedge i_clk) begin
        r_put_byte <= n_put_byte;
        if (emit && out_ready) begin
            r_kind   <= e_kind;
            r_waddr  <= (e_kind != KIND_WRITE) ? '0 : (use_fmt_addr ? slot_addr : e_addr_raw);
            r_wdata  <= e_data;
            r_sv     <= e_sv;
            r_last   <= e_last;
            r_lvalid <= (e_kind != KIND_WRITE) && n_newest_valid;
            r_laddr  <= ((e_kind != KIND_WRITE) && n_newest_valid) ?
                        slot_addr + t_addr'(5) : '0;
            r_lseq   <= ((e_kind != KIND_WRITE) && n_newest_valid) ? n_newest_seq : '0;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_kind                   = r_kind;
    assign o_write_address          = r_waddr;
    assign o_write_data             = r_wdata;
    assign o_slot_valid             = r_sv;
    assign o_latest_valid           = r_lvalid;
    assign o_latest_payload_address = r_laddr;
    assign o_latest_sequence        = r_lseq;
    assign o_last                   = r_last;

endmodule

@@ hw/rtl/crc_checked_ring_record_log_core.sv @@
// channel  | handshake                          | payload
// config   | i_cfg_wr_en                        | i_cfg_index, i_cfg_wr_data
// input    | i_in_valid / o_in_stall            | i_op, i_data_byte
// output   | o_out_valid / i_out_stall          | o_kind .. o_last
//
// the first put byte runs the remainder unit when a newest record exists, then takes an
// address step and the sequence writes before its payload write; the final put byte adds
// the crc and mark writes, all set by the back sequencer
// items pass the front register and the queue; results leave through the result register
// synchronous active-low reset; no clearing pass, the block takes items right after reset
// a 4-entry queue lets the front keep taking items while the output is stalled
module crc_checked_ring_record_log_core import crcl_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [2:0]              i_op,
    input  logic [7:0]              i_data_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_kind,
    output logic [ADDRESS_BITS-1:0] o_write_address,
    output logic [7:0]              o_write_data,
    output logic                    o_slot_valid,
    output logic                    o_latest_valid,
    output logic [ADDRESS_BITS-1:0] o_latest_payload_address,
    output logic [31:0]             o_latest_sequence,
    output logic                    o_last
);

    t_cfg  r_cfg;
    logic  push, q_full, q_valid, q_pop;
    t_item push_item, q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base  <= '0;
            r_cfg.len   <= LEN_W'(16);
            r_cfg.count <= SLOT_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BASE_ADDRESS:   r_cfg.base  <= i_cfg_wr_data[LEN_W-1:0];
                REG_PAYLOAD_LENGTH: r_cfg.len   <= i_cfg_wr_data[LEN_W-1:0];
                REG_SLOT_COUNT:     r_cfg.count <= i_cfg_wr_data[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    crcl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    crcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    crcl_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg                    (r_cfg),
        .i_q_valid                (q_valid),
        .i_q_item                 (q_head),
        .o_q_pop                  (q_pop),
        .o_out_valid              (o_out_valid),
        .i_out_stall              (i_out_stall),
        .o_kind                   (o_kind),
        .o_write_address          (o_write_address),
        .o_write_data             (o_write_data),
        .o_slot_valid             (o_slot_valid),
        .o_latest_valid           (o_latest_valid),
        .o_latest_payload_address (o_latest_payload_address),
        .o_latest_sequence        (o_latest_sequence),
        .o_last                   (o_last)
    );

endmodule

@@ hw/rtl/crcl_checker.sv @@
`include "crc_checked_ring_record_log_core_macros.svh"

module crcl_checker import crcl_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [1:0]              o_kind,
    input logic [ADDRESS_BITS-1:0] o_write_address,
    input logic [7:0]              o_write_data,
    input logic                    o_slot_valid,
    input logic                    o_latest_valid,
    input logic [ADDRESS_BITS-1:0] o_latest_payload_address,
    input logic [31:0]             o_latest_sequence,
    input logic                    o_last
);

    // a stalled result holds still
    `CRCL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_write_address) && $stable(o_write_data) && $stable(o_latest_sequence) && $stable(o_last), "stalled result changed")

    // write requests carry no record info
    `CRCL_ASSERT_NOW(a_write_clean, o_out_valid && o_kind == KIND_WRITE, !o_slot_valid && !o_latest_valid && o_latest_payload_address == '0 && o_latest_sequence == '0, "write result carries info")

    // a closing write is a commit mark or a free mark
    `CRCL_ASSERT_NOW(a_last_mark, o_out_valid && o_kind == KIND_WRITE && o_last, o_write_data == MARK_COMMIT || o_write_data == MARK_FREE, "closing write is not a mark")

    // status reports never close a sequence and never flag a slot as valid
    `CRCL_ASSERT_NOW(a_status_flags, o_out_valid && o_kind == KIND_STATUS, !o_last && !o_slot_valid && o_write_address == '0, "status report flags set")

endmodule

bind crc_checked_ring_record_log_core crcl_checker #(
    .ADDRESS_BITS (ADDRESS_BITS)
) u_checker (.*);
